### sv/kae_pkg.sv
// ----------------------------------------------------------------------------
// kae_pkg - shared types and constants for the altitude estimator
// Register indexes, sequencer codes, widths and the saturation helper.
// ----------------------------------------------------------------------------
package kae_pkg;

	localparam int FRACTION_BITS = 16;  // fraction bits of state, gains, readings
	localparam int DT_FRAC       = 16;  // fraction bits of the time step
	localparam int VAL_W         = 32;
	localparam int DT_W          = 16;
	localparam int OPND_W        = VAL_W + 1;        // multiplier operand width
	localparam int PROD_W        = 2 * OPND_W;
	// holds a value plus two rounded gain terms
	localparam int ACC_W         = PROD_W - FRACTION_BITS + 2;
	localparam int STEP_W        = 4;
	localparam int DATA_W        = 3 * VAL_W;
	localparam int CFG_ADDR_W    = 3;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(13);

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic signed [PROD_W-1:0] HALF_DT   = PROD_W'(1) << (DT_FRAC - 1);
	localparam logic signed [PROD_W-1:0] HALF_GAIN = PROD_W'(1) << (FRACTION_BITS - 1);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_MEAS = 1'b1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_TIME_STEP    = 3'd0,
		REG_GAIN_POS_ALT = 3'd1,
		REG_GAIN_POS_ACC = 3'd2,
		REG_GAIN_VEL_ALT = 3'd3,
		REG_GAIN_VEL_ACC = 3'd4,
		REG_GAIN_ACC_ALT = 3'd5,
		REG_GAIN_ACC_ACC = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_FINISH
	} seq_state_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_DT_DT,
		MUL_DT_VEL,
		MUL_HDT2_ACC,
		MUL_DT_ACC,
		MUL_GPA_EALT,
		MUL_GPC_EACC,
		MUL_GVA_EALT,
		MUL_GVC_EACC,
		MUL_GAA_EALT,
		MUL_GAC_EACC
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_POS,
		ACC_ADD,
		ACC_LOAD_VEL_ADD,
		ACC_LOAD_P_ADD,
		ACC_LOAD_V_ADD,
		ACC_LOAD_A_ADD
	} acc_op_t;

	typedef enum logic [3:0] {
		ST_NONE,
		ST_HDT2,
		ST_P,
		ST_V_INNOV,
		ST_POS,
		ST_VEL,
		ST_ACC,
		ST_LOAD
	} store_t;

	typedef struct packed {
		mul_op_t mul_op;
		acc_op_t acc_op;
		logic    shift_gain;  // round from FRACTION_BITS instead of DT_FRAC
		store_t  store;
		logic    out_load;
	} ctrl_t;

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] x);
		logic signed [VAL_W-1:0] r;
		if (x > ACC_W'(VAL_MAX))
			r = VAL_MAX;
		else if (x < ACC_W'(VAL_MIN))
			r = VAL_MIN;
		else
			r = x[VAL_W-1:0];
		return r;
	endfunction

endpackage

### sv/kae_mul.sv
// ----------------------------------------------------------------------------
// kae_mul - shared signed multiplier
// One signed 33x33 product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module kae_mul (
	input  logic                                clk,
	input  logic signed [kae_pkg::OPND_W-1:0]   a,
	input  logic signed [kae_pkg::OPND_W-1:0]   b,
	output logic signed [kae_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

### sv/kae_ctrl.sv
// ----------------------------------------------------------------------------
// kae_ctrl - update sequencer
// Steps the shared multiplier and accumulator through the predict and
// correct schedule; a load item takes a single step.
// ----------------------------------------------------------------------------
module kae_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            kind,
	input  logic            out_free,
	output logic            ready,
	output kae_pkg::ctrl_t  ctrl
);

	kae_pkg::seq_state_t               state_q, state_d;
	logic [kae_pkg::STEP_W-1:0]        step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kae_pkg::SEQ_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		step_d          = step_q;
		ready           = 1'b0;
		ctrl.mul_op     = kae_pkg::MUL_NONE;
		ctrl.acc_op     = kae_pkg::ACC_HOLD;
		ctrl.shift_gain = 1'b0;
		ctrl.store      = kae_pkg::ST_NONE;
		ctrl.out_load   = 1'b0;
		case (state_q)
			kae_pkg::SEQ_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = kae_pkg::SEQ_RUN;
					step_d  = '0;
				end
			end
			kae_pkg::SEQ_RUN: begin
				if (kind == kae_pkg::KIND_LOAD) begin
					ctrl.store = kae_pkg::ST_LOAD;
					state_d    = kae_pkg::SEQ_FINISH;
				end else begin
					// product issued in step k is used in step k+1
					case (step_q)
						4'd0: ctrl.mul_op = kae_pkg::MUL_DT_DT;
						4'd1: begin
							ctrl.store  = kae_pkg::ST_HDT2;
							ctrl.mul_op = kae_pkg::MUL_DT_VEL;
							ctrl.acc_op = kae_pkg::ACC_LOAD_POS;
						end
						4'd2: begin
							ctrl.acc_op = kae_pkg::ACC_ADD;
							ctrl.mul_op = kae_pkg::MUL_HDT2_ACC;
						end
						4'd3: begin
							ctrl.acc_op = kae_pkg::ACC_ADD;
							ctrl.mul_op = kae_pkg::MUL_DT_ACC;
						end
						4'd4: begin
							ctrl.store  = kae_pkg::ST_P;
							ctrl.acc_op = kae_pkg::ACC_LOAD_VEL_ADD;
						end
						4'd5: ctrl.store = kae_pkg::ST_V_INNOV;
						4'd6: ctrl.mul_op = kae_pkg::MUL_GPA_EALT;
						4'd7: begin
							ctrl.acc_op     = kae_pkg::ACC_LOAD_P_ADD;
							ctrl.shift_gain = 1'b1;
							ctrl.mul_op     = kae_pkg::MUL_GPC_EACC;
						end
						4'd8: begin
							ctrl.acc_op     = kae_pkg::ACC_ADD;
							ctrl.shift_gain = 1'b1;
							ctrl.mul_op     = kae_pkg::MUL_GVA_EALT;
						end
						4'd9: begin
							ctrl.store      = kae_pkg::ST_POS;
							ctrl.acc_op     = kae_pkg::ACC_LOAD_V_ADD;
							ctrl.shift_gain = 1'b1;
							ctrl.mul_op     = kae_pkg::MUL_GVC_EACC;
						end
						4'd10: begin
							ctrl.acc_op     = kae_pkg::ACC_ADD;
							ctrl.shift_gain = 1'b1;
							ctrl.mul_op     = kae_pkg::MUL_GAA_EALT;
						end
						4'd11: begin
							ctrl.store      = kae_pkg::ST_VEL;
							ctrl.acc_op     = kae_pkg::ACC_LOAD_A_ADD;
							ctrl.shift_gain = 1'b1;
							ctrl.mul_op     = kae_pkg::MUL_GAC_EACC;
						end
						4'd12: begin
							ctrl.acc_op     = kae_pkg::ACC_ADD;
							ctrl.shift_gain = 1'b1;
						end
						4'd13: ctrl.store = kae_pkg::ST_ACC;
						default: ;
					endcase
					if (step_q == kae_pkg::STEP_LAST)
						state_d = kae_pkg::SEQ_FINISH;
					else
						step_d = step_q + 1'b1;
				end
			end
			kae_pkg::SEQ_FINISH: begin
				if (out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = kae_pkg::SEQ_IDLE;
				end
			end
			default: state_d = kae_pkg::SEQ_IDLE;
		endcase
	end

endmodule

### sv/kalman_altitude_estimator_top.sv
// ----------------------------------------------------------------------------
// kalman_altitude_estimator_top - three-state altitude estimator
// Position/velocity/acceleration estimate with software-supplied gain.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects the item kind (0 load estimate, 1 measurement),
// s_tdata carries position, velocity and acceleration. Every accepted beat
// yields one result beat on the output stream carrying the estimate after
// that item.
// A measurement is 14 sequencer steps through the one shared 33x33 multiplier
// and the accumulator, a load is 1 step; the finish state then moves the
// estimate to the output register once the output register is free.
// s_tready is high only while the sequencer is idle. A finished result waits
// in the output register; a new beat is taken meanwhile, and its result
// waits in the sequencer until the receiver takes the previous beat.
// Configuration is written through cfg_wen/cfg_addr/cfg_wdata; the user must write it while idle (not enforced).
// Reset clears the estimate, the time step and all gains to zero.
// ----------------------------------------------------------------------------
module kalman_altitude_estimator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [kae_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [kae_pkg::VAL_W-1:0]            cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [kae_pkg::DATA_W-1:0]           s_tdata,   // position, velocity, acceleration
	input  logic                                 s_tuser,   // kind
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [kae_pkg::DATA_W-1:0]           m_tdata    // est_position, est_velocity, est_acceleration
);

	localparam int VW = kae_pkg::VAL_W;
	localparam int OW = kae_pkg::OPND_W;
	localparam int AW = kae_pkg::ACC_W;
	localparam int PW = kae_pkg::PROD_W;

	// configuration
	logic [kae_pkg::DT_W-1:0] time_step_q;
	logic signed [VW-1:0]     g_pa_q, g_pc_q, g_va_q, g_vc_q, g_aa_q, g_ac_q;

	// input item
	logic                     kind_q;
	logic signed [VW-1:0]     m_pos_q, m_vel_q, m_acc_q;

	// estimate
	logic signed [VW-1:0]     pos_q, vel_q, acc_st_q;

	// working registers
	logic [kae_pkg::DT_W-1:0] hdt2_q;
	logic signed [VW-1:0]     p_q, v_q;
	logic signed [OW-1:0]     e_alt_q, e_acc_q;
	logic signed [AW-1:0]     acc_q;
	logic [kae_pkg::DATA_W-1:0] out_data_q;
	logic                     out_valid_q;

	logic                     in_beat, out_free, seq_ready;
	kae_pkg::ctrl_t           ctrl;
	logic signed [OW-1:0]     mul_a, mul_b;
	logic signed [PW-1:0]     prod_q, rnd_dt, rnd_gain;
	logic signed [AW-1:0]     term;
	logic [33:0]              hdt2_sum;

	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = seq_ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
			g_pa_q      <= '0;
			g_pc_q      <= '0;
			g_va_q      <= '0;
			g_vc_q      <= '0;
			g_aa_q      <= '0;
			g_ac_q      <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				kae_pkg::REG_TIME_STEP:    time_step_q <= cfg_wdata[kae_pkg::DT_W-1:0];
				kae_pkg::REG_GAIN_POS_ALT: g_pa_q <= cfg_wdata;
				kae_pkg::REG_GAIN_POS_ACC: g_pc_q <= cfg_wdata;
				kae_pkg::REG_GAIN_VEL_ALT: g_va_q <= cfg_wdata;
				kae_pkg::REG_GAIN_VEL_ACC: g_vc_q <= cfg_wdata;
				kae_pkg::REG_GAIN_ACC_ALT: g_aa_q <= cfg_wdata;
				kae_pkg::REG_GAIN_ACC_ACC: g_ac_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			kind_q  <= s_tuser;
			m_pos_q <= s_tdata[VW-1:0];
			m_vel_q <= s_tdata[2*VW-1:VW];
			m_acc_q <= s_tdata[3*VW-1:2*VW];
		end
	end

	kae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_beat),
		.kind     (kind_q),
		.out_free (out_free),
		.ready    (seq_ready),
		.ctrl     (ctrl)
	);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_op)
			kae_pkg::MUL_DT_DT: begin
				mul_a = {{(OW-kae_pkg::DT_W){1'b0}}, time_step_q};
				mul_b = {{(OW-kae_pkg::DT_W){1'b0}}, time_step_q};
			end
			kae_pkg::MUL_DT_VEL: begin
				mul_a = {{(OW-kae_pkg::DT_W){1'b0}}, time_step_q};
				mul_b = {vel_q[VW-1], vel_q};
			end
			kae_pkg::MUL_HDT2_ACC: begin
				mul_a = {{(OW-kae_pkg::DT_W){1'b0}}, hdt2_q};
				mul_b = {acc_st_q[VW-1], acc_st_q};
			end
			kae_pkg::MUL_DT_ACC: begin
				mul_a = {{(OW-kae_pkg::DT_W){1'b0}}, time_step_q};
				mul_b = {acc_st_q[VW-1], acc_st_q};
			end
			kae_pkg::MUL_GPA_EALT: begin
				mul_a = {g_pa_q[VW-1], g_pa_q};
				mul_b = e_alt_q;
			end
			kae_pkg::MUL_GPC_EACC: begin
				mul_a = {g_pc_q[VW-1], g_pc_q};
				mul_b = e_acc_q;
			end
			kae_pkg::MUL_GVA_EALT: begin
				mul_a = {g_va_q[VW-1], g_va_q};
				mul_b = e_alt_q;
			end
			kae_pkg::MUL_GVC_EACC: begin
				mul_a = {g_vc_q[VW-1], g_vc_q};
				mul_b = e_acc_q;
			end
			kae_pkg::MUL_GAA_EALT: begin
				mul_a = {g_aa_q[VW-1], g_aa_q};
				mul_b = e_alt_q;
			end
			kae_pkg::MUL_GAC_EACC: begin
				mul_a = {g_ac_q[VW-1], g_ac_q};
				mul_b = e_acc_q;
			end
			default: ;
		endcase
	end

	kae_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// round half up, ties toward +inf
	assign rnd_dt   = (prod_q + kae_pkg::HALF_DT) >>> kae_pkg::DT_FRAC;
	assign rnd_gain = (prod_q + kae_pkg::HALF_GAIN) >>> kae_pkg::FRACTION_BITS;
	assign term     = ctrl.shift_gain ? rnd_gain[AW-1:0] : rnd_dt[AW-1:0];
	// dt*dt is non-negative and below 2^32
	assign hdt2_sum = prod_q[33:0] + 34'h1_0000;

	always_ff @(posedge clk) begin
		case (ctrl.acc_op)
			kae_pkg::ACC_LOAD_POS:     acc_q <= AW'(pos_q);
			kae_pkg::ACC_ADD:          acc_q <= acc_q + term;
			kae_pkg::ACC_LOAD_VEL_ADD: acc_q <= AW'(vel_q) + term;
			kae_pkg::ACC_LOAD_P_ADD:   acc_q <= AW'(p_q) + term;
			kae_pkg::ACC_LOAD_V_ADD:   acc_q <= AW'(v_q) + term;
			kae_pkg::ACC_LOAD_A_ADD:   acc_q <= AW'(acc_st_q) + term;
			default: ;
		endcase
		case (ctrl.store)
			kae_pkg::ST_HDT2: hdt2_q <= hdt2_sum[32:17];
			kae_pkg::ST_P:    p_q <= kae_pkg::sat_val(acc_q);
			kae_pkg::ST_V_INNOV: begin
				v_q     <= kae_pkg::sat_val(acc_q);
				e_alt_q <= {m_pos_q[VW-1], m_pos_q} - {p_q[VW-1], p_q};
				e_acc_q <= {m_acc_q[VW-1], m_acc_q} - {acc_st_q[VW-1], acc_st_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			vel_q    <= '0;
			acc_st_q <= '0;
		end else begin
			case (ctrl.store)
				kae_pkg::ST_POS: pos_q    <= kae_pkg::sat_val(acc_q);
				kae_pkg::ST_VEL: vel_q    <= kae_pkg::sat_val(acc_q);
				kae_pkg::ST_ACC: acc_st_q <= kae_pkg::sat_val(acc_q);
				kae_pkg::ST_LOAD: begin
					pos_q    <= m_pos_q;
					vel_q    <= m_vel_q;
					acc_st_q <= m_acc_q;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load)
			out_data_q <= {acc_st_q, vel_q, pos_q};
	end

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_load_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_tuser == kae_pkg::KIND_LOAD && !m_tvalid) |-> ##3 m_tvalid)
		else $error("load result missing");

	a_meas_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_tuser == kae_pkg::KIND_MEAS && !m_tvalid) |-> ##16 m_tvalid)
		else $error("measurement result missing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid_q || m_tready))
		else $error("result overwrote an untaken beat");

endmodule
